FILE: rtl/eesq_pkg.sv
// Shared types, codes and constants of the SPI EEPROM command sequencer.
// Used by the front, queue and back modules and by the top level.
// Depends on nothing.
`default_nettype none

package eesq_pkg;

   // Burst and address constants.
   localparam int MAX_BURST         = 32;
   localparam int ADDRESS_STRIDE    = 32;
   localparam int BURST_COUNT_WIDTH = $clog2(MAX_BURST + 1);

   // Job queue between the front and back parts (power of two).
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Request kinds.
   localparam logic [2:0] KIND_WRITE_DATA  = 3'd0;
   localparam logic [2:0] KIND_WRITE_EN    = 3'd1;
   localparam logic [2:0] KIND_WRITE_DIS   = 3'd2;
   localparam logic [2:0] KIND_READ_BYTE   = 3'd3;
   localparam logic [2:0] KIND_READ_STATUS = 3'd4;
   localparam logic [2:0] KIND_CYCLE_DONE  = 3'd5;

   // Modes.
   localparam logic [1:0] MODE_WAITING = 2'd0;
   localparam logic [1:0] MODE_ENABLED = 2'd1;
   localparam logic [1:0] MODE_CYCLE   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BUSY       = 2'd1;
   localparam logic [1:0] STATUS_WRONG_MODE = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW   = 2'd3;

   // EEPROM opcodes and dummy bytes.
   localparam logic [7:0] CMD_WREN     = 8'h06;
   localparam logic [7:0] CMD_WRDI     = 8'h04;
   localparam logic [7:0] CMD_READ     = 8'h03;
   localparam logic [7:0] CMD_WRITE    = 8'h02;
   localparam logic [7:0] CMD_RDSR     = 8'h05;
   localparam logic [7:0] READ_DUMMY   = 8'h0F;
   localparam logic [7:0] STATUS_DUMMY = 8'hFF;

   // One job: an optional WREN frame, an optional command byte, optional
   // three address bytes, and always one closing result.
   typedef struct packed {
      logic        with_wren;
      logic        with_cmd;
      logic        with_address;
      logic [7:0]  cmd_byte;
      logic [23:0] address;
      logic        tail_valid;
      logic [7:0]  tail_byte;
      logic        tail_frame_end;
      logic [1:0]  status;
      logic [1:0]  mode;
   } job_type;

endpackage

`default_nettype wire

FILE: rtl/eesq_front.sv
// Front part: accepts requests, tracks mode and burst state, emits jobs.
// Depends on eesq_pkg.
`default_nettype none

module eesq_front
   import eesq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [23:0] req_read_address,
   input  wire logic        queue_full,
   output logic             push,
   output job_type          push_job
);

   logic [1:0]                   mode_ff, mode_in;
   logic [23:0]                  write_address_ff, write_address_in;
   logic [BURST_COUNT_WIDTH-1:0] burst_count_ff, burst_count_in, count_cur;
   logic                         burst_open_ff, burst_open_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      mode_in          = mode_ff;
      write_address_in = write_address_ff;
      burst_count_in   = burst_count_ff;
      burst_open_in    = burst_open_ff;
      count_cur        = burst_open_ff ? burst_count_ff : '0;
      push_job         = '0;
      push_job.address = write_address_ff;

      if (burst_open_ff && req_kind != KIND_WRITE_DATA) begin
         push_job.status = STATUS_WRONG_MODE;
      end else begin
         unique case (req_kind)
            KIND_WRITE_DATA: begin
               if (mode_ff == MODE_CYCLE) begin
                  push_job.status = STATUS_BUSY;
               end else begin
                  if (!burst_open_ff) begin
                     push_job.with_wren    = (mode_ff == MODE_WAITING);
                     push_job.with_cmd     = 1'b1;
                     push_job.with_address = 1'b1;
                     push_job.cmd_byte     = CMD_WRITE;
                     mode_in               = MODE_ENABLED;
                     burst_open_in         = 1'b1;
                  end
                  if (count_cur < BURST_COUNT_WIDTH'(MAX_BURST)) begin
                     push_job.tail_valid     = 1'b1;
                     push_job.tail_byte      = req_data_byte;
                     push_job.tail_frame_end = req_last_byte;
                     burst_count_in          = count_cur + 1'b1;
                  end else begin
                     push_job.tail_frame_end = req_last_byte;
                     push_job.status         = STATUS_OVERFLOW;
                     burst_count_in          = count_cur;
                  end
                  if (req_last_byte) begin
                     burst_open_in    = 1'b0;
                     burst_count_in   = '0;
                     write_address_in = write_address_ff + 24'(ADDRESS_STRIDE);
                     mode_in          = MODE_CYCLE;
                  end
               end
            end
            KIND_WRITE_EN: begin
               if (mode_ff == MODE_WAITING) begin
                  push_job.tail_valid     = 1'b1;
                  push_job.tail_byte      = CMD_WREN;
                  push_job.tail_frame_end = 1'b1;
                  mode_in                 = MODE_ENABLED;
               end else begin
                  push_job.status = STATUS_WRONG_MODE;
               end
            end
            KIND_WRITE_DIS: begin
               if (mode_ff == MODE_ENABLED) begin
                  push_job.tail_valid     = 1'b1;
                  push_job.tail_byte      = CMD_WRDI;
                  push_job.tail_frame_end = 1'b1;
                  mode_in                 = MODE_WAITING;
               end else begin
                  push_job.status = STATUS_WRONG_MODE;
               end
            end
            KIND_READ_BYTE: begin
               if (mode_ff == MODE_CYCLE) begin
                  push_job.status = STATUS_BUSY;
               end else begin
                  push_job.with_cmd       = 1'b1;
                  push_job.with_address   = 1'b1;
                  push_job.cmd_byte       = CMD_READ;
                  push_job.address        = req_read_address;
                  push_job.tail_valid     = 1'b1;
                  push_job.tail_byte      = READ_DUMMY;
                  push_job.tail_frame_end = 1'b1;
               end
            end
            KIND_READ_STATUS: begin
               push_job.with_cmd       = 1'b1;
               push_job.cmd_byte       = CMD_RDSR;
               push_job.tail_valid     = 1'b1;
               push_job.tail_byte      = STATUS_DUMMY;
               push_job.tail_frame_end = 1'b1;
            end
            KIND_CYCLE_DONE: begin
               if (mode_ff == MODE_CYCLE) begin
                  mode_in = MODE_WAITING;
               end else begin
                  push_job.status = STATUS_WRONG_MODE;
               end
            end
            default: begin
               push_job.status = STATUS_WRONG_MODE;
            end
         endcase
      end
      push_job.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_WAITING;
         write_address_ff <= '0;
         burst_count_ff   <= '0;
         burst_open_ff    <= 1'b0;
      end else if (push) begin
         mode_ff          <= mode_in;
         write_address_ff <= write_address_in;
         burst_count_ff   <= burst_count_in;
         burst_open_ff    <= burst_open_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/eesq_queue.sv
// Short job queue that decouples the front and back parts.
// Depends on eesq_pkg.
`default_nettype none

module eesq_queue
   import eesq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output job_type      head_job
);

   job_type                    entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;

   assign full     = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         // The depth is a power of two, so the pointers wrap on their own.
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

FILE: rtl/eesq_back.sv
// Back part: walks the queue's head job into the result register, one result per cycle
// while the receiver does not stall. Depends on eesq_pkg.
`default_nettype none

module eesq_back
   import eesq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type head_job,
   input  wire logic    queue_empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic         rsp_tx_valid,
   output logic [7:0]   rsp_tx_byte,
   output logic         rsp_frame_end,
   output logic         rsp_last,
   output logic [1:0]   rsp_status,
   output logic [1:0]   rsp_mode
);

   // Sequencer steps, one per result a job can cause.
   localparam logic [2:0] PIECE_WREN  = 3'd0;
   localparam logic [2:0] PIECE_CMD   = 3'd1;
   localparam logic [2:0] PIECE_ADDR2 = 3'd2;
   localparam logic [2:0] PIECE_ADDR1 = 3'd3;
   localparam logic [2:0] PIECE_ADDR0 = 3'd4;
   localparam logic [2:0] PIECE_TAIL  = 3'd5;

   function automatic logic [2:0] piece_after(input job_type job, input logic [2:0] piece);
      logic [2:0] next;
      next = PIECE_TAIL;
      unique case (piece)
         PIECE_WREN:  next = job.with_cmd ? PIECE_CMD
                           : (job.with_address ? PIECE_ADDR2 : PIECE_TAIL);
         PIECE_CMD:   next = job.with_address ? PIECE_ADDR2 : PIECE_TAIL;
         PIECE_ADDR2: next = PIECE_ADDR1;
         PIECE_ADDR1: next = PIECE_ADDR0;
         default:     next = PIECE_TAIL;
      endcase
      return next;
   endfunction

   logic       rsp_valid_ff, mid_ff;
   logic [2:0] step_ff, piece;
   logic       advance, fire;
   logic       tx_valid_in, frame_end_in, last_in;
   logic [7:0] tx_byte_in;
   logic [1:0] status_in;
   logic       tx_valid_ff, frame_end_ff, last_ff;
   logic [7:0] tx_byte_ff;
   logic [1:0] status_ff, mode_ff;

   always_comb begin
      advance = !rsp_valid_ff || rsp_ready;
      fire    = advance && !queue_empty;
      if (mid_ff)                piece = step_ff;
      else if (head_job.with_wren) piece = PIECE_WREN;
      else                       piece = piece_after(head_job, PIECE_WREN);
      pop = fire && (piece == PIECE_TAIL);

      tx_valid_in  = 1'b1;
      tx_byte_in   = 8'h00;
      frame_end_in = 1'b0;
      last_in      = 1'b0;
      status_in    = STATUS_OK;
      unique case (piece)
         PIECE_WREN: begin
            tx_byte_in   = CMD_WREN;
            frame_end_in = 1'b1;
         end
         PIECE_CMD:   tx_byte_in = head_job.cmd_byte;
         PIECE_ADDR2: tx_byte_in = head_job.address[23:16];
         PIECE_ADDR1: tx_byte_in = head_job.address[15:8];
         PIECE_ADDR0: tx_byte_in = head_job.address[7:0];
         default: begin
            tx_valid_in  = head_job.tail_valid;
            tx_byte_in   = head_job.tail_byte;
            frame_end_in = head_job.tail_frame_end;
            last_in      = 1'b1;
            status_in    = head_job.status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mid_ff       <= 1'b0;
         step_ff      <= PIECE_WREN;
      end else if (advance) begin
         rsp_valid_ff <= !queue_empty;
         if (fire) begin
            mid_ff  <= (piece != PIECE_TAIL);
            step_ff <= piece_after(head_job, piece);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         tx_valid_ff  <= tx_valid_in;
         tx_byte_ff   <= tx_byte_in;
         frame_end_ff <= frame_end_in;
         last_ff      <= last_in;
         status_ff    <= status_in;
         mode_ff      <= head_job.mode;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_valid  = tx_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_last      = last_ff;
   assign rsp_status    = status_ff;
   assign rsp_mode      = mode_ff;

endmodule

`default_nettype wire

FILE: rtl/spi_eeprom_command_sequencer.sv
// Flow: a request accepted by the front is written into the job queue, and the back part
// then loads its first result into the result register, from which the receiver takes it.
// One result per cycle while the receiver does not stall; a request gives one to six
// results, one per part of its job.
// The front accepts one request per cycle while the two-entry job queue has room.
// Reset is synchronous, active high: mode waiting, write pointer and burst state zero,
// queue empty and no result pending.
`default_nettype none

// Top level of the SPI EEPROM command sequencer. It ties together the front
// part (request decode and mode state), the job queue and the back part.
module spi_eeprom_command_sequencer
   import eesq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [23:0] req_read_address,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_frame_end,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_mode
);

   // The front decides everything about a request in the cycle it is
   // accepted: it updates the mode, the write pointer and the burst count,
   // and it describes the SPI bytes to send as one job. A job is an optional
   // WREN frame, an optional command byte, optional three address bytes and
   // one closing result that carries the status and the last flag.
   job_type push_job, head_job;
   logic    push, pop, queue_full, queue_empty;

   eesq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_read_address (req_read_address),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   // The queue lets the front keep taking requests while the back is still
   // sending the bytes of earlier ones or the receiver stalls.
   eesq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   // The back steps through the head job's parts, one result per cycle while the
   // receiver does not stall, and releases the job when its closing result is loaded.
   eesq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_valid  (rsp_tx_valid),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .rsp_mode      (rsp_mode)
   );

endmodule

`default_nettype wire

FILE: rtl/eesq_checker.sv
// Port-level checks for the SPI EEPROM command sequencer, bound to the top level.
// Depends on eesq_pkg and on the top level's port names.
`default_nettype none

module eesq_checker
   import eesq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_tx_valid,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_frame_end,
   input wire logic        rsp_last,
   input wire logic [1:0]  rsp_status,
   input wire logic [1:0]  rsp_mode
);

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte)
         && $stable(rsp_status) && $stable(rsp_last) && $stable(rsp_mode))
      else $error("stalled result changed");

   // A result with no SPI byte carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'h00)
      else $error("idle result carries a byte");

   // A rejected or dropped request gives one result only, without a byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last && !rsp_tx_valid)
      else $error("nonzero status on a sent or non-final result");

   // Busy and wrong-mode results never release chip select.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BUSY || rsp_status == STATUS_WRONG_MODE)
         |-> !rsp_frame_end)
      else $error("rejected request released chip select");

endmodule

bind spi_eeprom_command_sequencer eesq_checker u_checker (.*);

`default_nettype wire

FILE: dv/spi_eeprom_command_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SPI EEPROM command sequencer top level.
// Depends on eesq_pkg and on spi_eeprom_command_sequencer; it needs nothing else.

module spi_eeprom_command_sequencer_tb
   import eesq_pkg::*;
();

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 2;
   localparam int RANDOM_ITEMS  = 50;
   localparam int STEADY_ITEMS  = 30;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 12;
   // No request moves for this many cycles only if the block has hung. The slowest
   // correct stretch is a long sender gap plus the pipeline plus a long result stall.
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_RESULTS   = 6;

   // Kinds past the last defined one; the block must reject them as wrong mode.
   localparam logic [2:0] KIND_SPARE_LOW  = 3'd6;
   localparam logic [2:0] KIND_SPARE_HIGH = 3'd7;

   // One SPI result as the block presents it on the rsp_ ports.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       last;
      logic [1:0] status;
      logic [1:0] mode;
   } spi_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_kind;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic [23:0] req_read_address;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_frame_end;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_mode;

   spi_eeprom_command_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_valid     (rsp_tx_valid),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .rsp_mode         (rsp_mode)
   );

   always #HALF_PERIOD clock = ~clock;

   // Shadow copy of the sequencer state, advanced once per accepted request.
   logic [1:0]  shadow_mode;
   logic [23:0] shadow_write_ptr;
   int unsigned shadow_burst_len;
   bit          shadow_burst_open;

   // Results of the request being predicted, before last and mode are filled in.
   spi_result_type staged [MAX_RESULTS];
   int             staged_count;

   // SPI results still owed by the block, oldest first.
   spi_result_type pending_results [$];

   // When set, neither side idles: the sender sends back to back and the
   // receiver holds rsp_ready high.
   bit steady_flow = 1'b0;

   int failures        = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int bursts_closed   = 0;
   int dropped_bytes   = 0;
   int stall_left      = 0;
   int quiet_cycles    = 0;

   function automatic void stage_result(logic tx_valid, logic [7:0] value,
                                        logic frame_end, logic [1:0] status);
      staged[staged_count] = {tx_valid, value, frame_end, 1'b0, status, MODE_WAITING};
      staged_count++;
   endfunction

   function automatic void stage_address(logic [23:0] address);
      stage_result(1'b1, address[23:16], 1'b0, STATUS_OK);
      stage_result(1'b1, address[15:8], 1'b0, STATUS_OK);
      stage_result(1'b1, address[7:0], 1'b0, STATUS_OK);
   endfunction

   // Works out the SPI bytes that one accepted request causes and queues them.
   // A rejected request gives one empty result with a nonzero status and leaves
   // the shadow state alone.
   function automatic void predict_spi_bytes(logic [2:0] kind, logic [7:0] data_value,
                                             logic last_flag, logic [23:0] address);
      staged_count = 0;
      if (shadow_burst_open && kind != KIND_WRITE_DATA) begin
         // Nothing but data bytes may enter an open burst.
         stage_result(1'b0, 8'h00, 1'b0, STATUS_WRONG_MODE);
      end else begin
         case (kind)
            KIND_WRITE_DATA: begin
               if (shadow_mode == MODE_CYCLE) begin
                  stage_result(1'b0, 8'h00, 1'b0, STATUS_BUSY);
               end else begin
                  if (!shadow_burst_open) begin
                     // A burst from waiting carries its own WREN frame first.
                     if (shadow_mode == MODE_WAITING) begin
                        stage_result(1'b1, CMD_WREN, 1'b1, STATUS_OK);
                     end
                     shadow_mode = MODE_ENABLED;
                     stage_result(1'b1, CMD_WRITE, 1'b0, STATUS_OK);
                     stage_address(shadow_write_ptr);
                     shadow_burst_open = 1'b1;
                     shadow_burst_len  = 0;
                  end
                  if (shadow_burst_len < MAX_BURST) begin
                     stage_result(1'b1, data_value, last_flag, STATUS_OK);
                     shadow_burst_len++;
                  end else begin
                     // Past the page the byte is dropped; a final one still ends the frame.
                     stage_result(1'b0, 8'h00, last_flag, STATUS_OVERFLOW);
                     dropped_bytes++;
                  end
                  if (last_flag) begin
                     shadow_burst_open = 1'b0;
                     shadow_burst_len  = 0;
                     shadow_write_ptr  = shadow_write_ptr + 24'(ADDRESS_STRIDE);
                     shadow_mode       = MODE_CYCLE;
                     bursts_closed++;
                  end
               end
            end
            KIND_WRITE_EN: begin
               if (shadow_mode == MODE_WAITING) begin
                  stage_result(1'b1, CMD_WREN, 1'b1, STATUS_OK);
                  shadow_mode = MODE_ENABLED;
               end else begin
                  stage_result(1'b0, 8'h00, 1'b0, STATUS_WRONG_MODE);
               end
            end
            KIND_WRITE_DIS: begin
               if (shadow_mode == MODE_ENABLED) begin
                  stage_result(1'b1, CMD_WRDI, 1'b1, STATUS_OK);
                  shadow_mode = MODE_WAITING;
               end else begin
                  stage_result(1'b0, 8'h00, 1'b0, STATUS_WRONG_MODE);
               end
            end
            KIND_READ_BYTE: begin
               if (shadow_mode == MODE_CYCLE) begin
                  stage_result(1'b0, 8'h00, 1'b0, STATUS_BUSY);
               end else begin
                  stage_result(1'b1, CMD_READ, 1'b0, STATUS_OK);
                  stage_address(address);
                  stage_result(1'b1, READ_DUMMY, 1'b1, STATUS_OK);
               end
            end
            KIND_READ_STATUS: begin
               stage_result(1'b1, CMD_RDSR, 1'b0, STATUS_OK);
               stage_result(1'b1, STATUS_DUMMY, 1'b1, STATUS_OK);
            end
            KIND_CYCLE_DONE: begin
               if (shadow_mode == MODE_CYCLE) begin
                  shadow_mode = MODE_WAITING;
                  stage_result(1'b0, 8'h00, 1'b0, STATUS_OK);
               end else begin
                  stage_result(1'b0, 8'h00, 1'b0, STATUS_WRONG_MODE);
               end
            end
            default: begin
               stage_result(1'b0, 8'h00, 1'b0, STATUS_WRONG_MODE);
            end
         endcase
      end
      // Every result of the request reports the mode after it; the final one is flagged.
      for (int k = 0; k < staged_count; k++) begin
         staged[k].last = (k == staged_count - 1);
         staged[k].mode = shadow_mode;
         pending_results.push_back(staged[k]);
      end
   endfunction

   // Most gaps are short, a few are long, and steady flow turns them off.
   function automatic int pick_gap();
      int roll;
      if (steady_flow) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic void report_failure(string what, spi_result_type wanted,
                                          spi_result_type observed);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t %s: expected tx_valid=%0b tx_byte=%02h frame_end=%0b last=%0b",
                  $time, what, wanted.tx_valid, wanted.tx_byte, wanted.frame_end,
                  wanted.last);
         $display("   status=%0d mode=%0d; got tx_valid=%0b tx_byte=%02h frame_end=%0b",
                  wanted.status, wanted.mode, observed.tx_valid, observed.tx_byte,
                  observed.frame_end);
         $display("   last=%0b status=%0d mode=%0d", observed.last, observed.status,
                  observed.mode);
      end
   endfunction

   // Sends one request after a random gap and returns in the time step of the
   // edge that accepted it. Valid is only lowered when a gap follows, so a
   // back-to-back request keeps valid high across the edge.
   task automatic send_request(input logic [2:0] kind, input logic [7:0] data_value,
                               input logic last_flag, input logic [23:0] address);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_data_byte    <= data_value;
      req_last_byte    <= last_flag;
      req_read_address <= address;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_spi_bytes(kind, data_value, last_flag, address);
      requests_sent++;
   endtask

   // The sender holds off until every owed result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_noise();
      send_request(3'($urandom_range(0, 7)), 8'($urandom()), 1'($urandom()),
                   24'($urandom()));
   endtask

   // A write burst of random bytes. When closed is clear no byte carries the
   // final flag, which leaves the burst open for whatever comes next. Now and
   // then a stray request lands inside the open burst.
   task automatic write_burst(input int count, input bit closed);
      for (int i = 0; i < count; i++) begin
         if (i > 0 && $urandom_range(0, 11) == 0) begin
            send_request(3'($urandom_range(1, 7)), 8'($urandom()), 1'($urandom()),
                         24'($urandom()));
         end
         send_request(KIND_WRITE_DATA, 8'($urandom()), closed && (i == count - 1),
                      24'($urandom()));
      end
   endtask

   // One well-formed step of host traffic picked from the shadow mode, or noise.
   task automatic send_random_scenario();
      int roll;
      int count;
      logic [23:0] address;
      roll = $urandom_range(0, 99);
      if (shadow_mode == MODE_CYCLE && !shadow_burst_open && roll < 55) begin
         send_request(KIND_CYCLE_DONE, 8'($urandom()), 1'($urandom()), 24'($urandom()));
      end else if (roll < 45) begin
         count = $urandom_range(0, 99);
         if (count < 85) begin
            count = $urandom_range(1, 6);
         end else if (count < 95) begin
            count = $urandom_range(7, MAX_BURST);
         end else begin
            count = $urandom_range(MAX_BURST + 1, MAX_BURST + 3);
         end
         write_burst(count, $urandom_range(0, 9) != 0);
      end else if (roll < 60) begin
         case ($urandom_range(0, 3))
            0:       address = 24'h000000;
            1:       address = 24'hFFFFFF;
            default: address = 24'($urandom());
         endcase
         send_request(KIND_READ_BYTE, 8'($urandom()), 1'($urandom()), address);
      end else if (roll < 68) begin
         send_request(KIND_READ_STATUS, 8'($urandom()), 1'($urandom()), 24'($urandom()));
      end else if (roll < 76) begin
         send_request(KIND_WRITE_EN, 8'($urandom()), 1'($urandom()), 24'($urandom()));
      end else if (roll < 84) begin
         send_request(KIND_WRITE_DIS, 8'($urandom()), 1'($urandom()), 24'($urandom()));
      end else begin
         send_noise();
      end
   endtask

   // Requests that need no burst, starting from the waiting mode after reset:
   // rejections in the wrong mode, the spare kinds, and reads at both address ends.
   task automatic test_idle_requests();
      send_request(KIND_READ_STATUS, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_WRITE_DIS, 8'hFF, 1'b1, 24'hFFFFFF);
      send_request(KIND_CYCLE_DONE, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_SPARE_LOW, 8'hFF, 1'b1, 24'hFFFFFF);
      send_request(KIND_SPARE_HIGH, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_WRITE_EN, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_WRITE_EN, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_READ_BYTE, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_READ_BYTE, 8'h00, 1'b0, 24'hFFFFFF);
      send_request(KIND_WRITE_DIS, 8'h00, 1'b0, 24'h000000);
   endtask

   // A one-byte burst from waiting (WREN frame included), five requests of different kinds
   // during the write cycle, then a burst from write enabled with strays inside it.
   task automatic test_write_burst_flow();
      send_request(KIND_WRITE_DATA, 8'hA5, 1'b1, 24'h000000);
      send_request(KIND_WRITE_DATA, 8'h5A, 1'b0, 24'h000000);
      send_request(KIND_READ_BYTE, 8'h00, 1'b0, 24'h123456);
      send_request(KIND_WRITE_EN, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_READ_STATUS, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_CYCLE_DONE, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_WRITE_EN, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_WRITE_DATA, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_READ_STATUS, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_CYCLE_DONE, 8'h00, 1'b0, 24'h000000);
      send_request(KIND_WRITE_DATA, 8'hFF, 1'b1, 24'h000000);
      send_request(KIND_CYCLE_DONE, 8'h00, 1'b0, 24'h000000);
   endtask

   // A burst that exactly fills the page, then one that runs past it so that
   // bytes are dropped and the final dropped byte still releases chip select.
   task automatic test_burst_overflow();
      if (shadow_burst_open) begin
         send_request(KIND_WRITE_DATA, 8'($urandom()), 1'b1, 24'h000000);
      end
      if (shadow_mode == MODE_CYCLE) begin
         send_request(KIND_CYCLE_DONE, 8'h00, 1'b0, 24'h000000);
      end
      write_burst(MAX_BURST, 1'b1);
      send_request(KIND_CYCLE_DONE, 8'h00, 1'b0, 24'h000000);
      write_burst(MAX_BURST + $urandom_range(1, 3), 1'b1);
      send_request(KIND_CYCLE_DONE, 8'h00, 1'b0, 24'h000000);
   endtask

   // Random traffic with no idling on either side, then a full drain.
   task automatic test_steady_stream();
      int first;
      steady_flow = 1'b1;
      first = requests_sent;
      while (requests_sent - first < STEADY_ITEMS) send_random_scenario();
      wait_for_drain();
      steady_flow = 1'b0;
   endtask

   // The bulk of the run: random host traffic with random idling, and now and
   // then the sender holds off until the block has caught up.
   task automatic test_random_traffic();
      int first;
      first = requests_sent;
      while (requests_sent - first < RANDOM_ITEMS) begin
         send_random_scenario();
         if ($urandom_range(0, 19) == 0) begin
            wait_for_drain();
         end
      end
   endtask

   // Receiver side: random stalls on rsp_ready, most short and a few long.
   always @(posedge clock) begin
      if (steady_flow) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every accepted result is matched against the oldest owed one. Outputs are
   // sampled just after the edge, which still shows the values that the edge took.
   always @(posedge clock) begin
      spi_result_type observed;
      spi_result_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         observed = {rsp_tx_valid, rsp_tx_byte, rsp_frame_end, rsp_last, rsp_status,
                     rsp_mode};
         if (pending_results.size() == 0) begin
            report_failure("result with none owed", '0, observed);
         end else begin
            wanted = pending_results.pop_front();
            if (observed !== wanted) begin
               report_failure("result mismatch", wanted, observed);
            end
         end
         results_checked++;
      end
   end

   // Watchdog: a run in which nothing moves on either channel for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no request or result moved for %0d cycles, %0d results owed",
                  STALL_LIMIT, pending_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_WRITE_DATA;
      req_data_byte    = 8'h00;
      req_last_byte    = 1'b0;
      req_read_address = 24'h000000;
      shadow_mode       = MODE_WAITING;
      shadow_write_ptr  = 24'h000000;
      shadow_burst_len  = 0;
      shadow_burst_open = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_write_burst_flow();
      test_burst_overflow();
      test_steady_stream();
      test_random_traffic();

      // Let the block finish, then wait out DRAIN_CYCLES to catch any stray result.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         failures += pending_results.size();
         $display("%0d results were never delivered", pending_results.size());
      end

      $display("Sent %0d requests and checked %0d SPI results.", requests_sent,
               results_checked);
      $display("Closed %0d write bursts and saw %0d bytes dropped past the page.",
               bursts_closed, dropped_bytes);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
